// File: hdl/ceq_pkg.sv
// Shared types and constants for the coalescing event queue.
// No dependencies; used by ceq_cell, coalescing_event_queue, ceq_checker, ceq_scoreboard and the testbench.
package ceq_pkg;

    localparam int TIME_BITS  = 32;
    localparam int GAP_BITS   = 16;
    localparam int LIMIT_BITS = 6;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [GAP_BITS-1:0]   RATE_GAP_RESET    = GAP_BITS'(150);
    localparam logic [LIMIT_BITS-1:0] QUEUE_LIMIT_RESET = LIMIT_BITS'(30);

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_GAP    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUEUE_LIMIT = CFG_IDX_BITS'(1);

    // command codes carried in tuser
    localparam logic CMD_POST = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic shift;     // every cell takes its right neighbor's contents
        logic coalesce;  // first matching cell takes the new value and time
    } t_cell_ctl;

endpackage

// File: hdl/ceq_cell.sv
// One queue slot: topic, value and queued time, plus the registered topic match.
// Depends on ceq_pkg. Instantiated in a row by coalescing_event_queue.
module ceq_cell #(
    parameter int TOPIC_BITS = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_load,       // item transfer: latch compare
    input  logic                           i_valid,      // slot is below the fill count
    input  logic [TOPIC_BITS-1:0]          i_cmp_topic,
    input  ceq_pkg::t_cell_ctl             i_ctl,
    input  logic                           i_app_sel,    // append lands in this slot
    input  logic                           i_hit_before, // a slot to the left matched
    output logic                           o_hit_before,
    input  logic [TOPIC_BITS-1:0]          i_new_topic,
    input  logic [VALUE_BITS-1:0]          i_new_value,
    input  logic [ceq_pkg::TIME_BITS-1:0]  i_new_time,
    input  logic [TOPIC_BITS-1:0]          i_nbr_topic,
    input  logic [VALUE_BITS-1:0]          i_nbr_value,
    input  logic [ceq_pkg::TIME_BITS-1:0]  i_nbr_time,
    output logic [TOPIC_BITS-1:0]          o_topic,
    output logic [VALUE_BITS-1:0]          o_value,
    output logic [ceq_pkg::TIME_BITS-1:0]  o_time
);
    import ceq_pkg::*;

    logic [TOPIC_BITS-1:0] r_topic;
    logic [VALUE_BITS-1:0] r_value;
    logic [TIME_BITS-1:0]  r_time;
    logic                  r_match;
    logic                  n_wr;

    assign o_hit_before = i_hit_before | r_match;
    assign n_wr = i_ctl.coalesce ? (r_match & ~i_hit_before) : i_app_sel;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_match <= i_valid && (r_topic == i_cmp_topic);
        end
        if (n_wr) begin
            r_topic <= i_new_topic;
            r_value <= i_new_value;
            r_time  <= i_new_time;
        end else if (i_ctl.shift) begin
            r_topic <= i_nbr_topic;
            r_value <= i_nbr_value;
            r_time  <= i_nbr_time;
        end
    end

    assign o_topic = r_topic;
    assign o_value = r_value;
    assign o_time  = r_time;

endmodule

// File: hdl/coalescing_event_queue.sv
// Coalescing event queue with send rate limit: top level, a row of ceq_cell slots.
// Depends on ceq_pkg and ceq_cell.
//
//  channel   | direction | handshake                      | payload
//  s_axis    | in        | i_s_axis_tvalid/o_s_axis_tready | tdata fields, tuser command
//  m_axis    | out       | o_m_axis_tvalid/i_m_axis_tready | tdata result fields
//  cfg       | in        | i_cfg_valid/o_cfg_ready         | i_cfg_index, i_cfg_data
//
// The transfer cycle latches the item while every slot compares its topic; the
// later update cycle picks the first match and updates the slots.
// One item is in work at a time; the result register lets the next item in
// while a result waits. A full result register holds the update cycle.
// Reset (synchronous, active low) empties the queue and restores the registers;
// slot contents are not cleared. Config writes are taken in every cycle.
module coalescing_event_queue #(
    parameter int DEPTH      = 32,
    parameter int TOPIC_BITS = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // [TOPIC-1:0] topic, then event_value, now_ms, link_ready, zero fill
    input  logic [((TOPIC_BITS+VALUE_BITS+ceq_pkg::TIME_BITS+1+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic i_s_axis_tuser,   // [0] command
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // sent, sent_topic, sent_value, age_ms, coalesced, dropped_oldest, occupancy
    output logic [((TOPIC_BITS+VALUE_BITS+ceq_pkg::TIME_BITS+3+$clog2(DEPTH+1)+7)/8)*8-1:0]
                 o_m_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ceq_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ceq_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import ceq_pkg::*;

    localparam int CW     = $clog2(DEPTH+1);
    localparam int IW     = $clog2(DEPTH);
    localparam int CMPW   = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;
    localparam int OUT_RAW = TOPIC_BITS+VALUE_BITS+TIME_BITS+3+CW;
    localparam int OUT_W  = ((OUT_RAW+7)/8)*8;
    localparam int IN_VAL = TOPIC_BITS;
    localparam int IN_NOW = IN_VAL + VALUE_BITS;
    localparam int IN_LNK = IN_NOW + TIME_BITS;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);
    localparam logic [CW-1:0]   DEPTH_N = CW'(DEPTH);

    // item latched at transfer
    logic                  r_busy;
    logic                  r_cmd;
    logic [TOPIC_BITS-1:0] r_topic;
    logic [VALUE_BITS-1:0] r_value;
    logic [TIME_BITS-1:0]  r_now;
    logic                  r_link;

    logic [CW-1:0]         r_count;
    logic [TIME_BITS-1:0]  r_last_send;
    logic [GAP_BITS-1:0]   r_gap;
    logic [LIMIT_BITS-1:0] r_limit;

    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    logic                  w_load;
    logic                  w_go;
    t_cell_ctl             w_ctl;
    logic [DEPTH-1:0]      w_app_sel;
    logic [DEPTH:0]        w_hit;
    logic [TOPIC_BITS-1:0] w_topic [DEPTH];
    logic [VALUE_BITS-1:0] w_value [DEPTH];
    logic [TIME_BITS-1:0]  w_time  [DEPTH];

    logic [CMPW-1:0]       n_limit_eff;
    logic [CMPW-1:0]       n_count_ext;
    logic                  n_hit;
    logic                  n_drop;
    logic                  n_append;
    logic [IW-1:0]         n_app_idx;
    logic                  n_send_ok;
    logic [TIME_BITS-1:0]  n_since;
    logic [CW-1:0]         n_count;
    logic [OUT_W-1:0]      n_out_data;

    assign o_s_axis_tready = !r_busy;
    assign o_cfg_ready     = 1'b1;
    assign w_load = i_s_axis_tvalid && !r_busy;
    assign w_go   = r_busy && (!r_out_valid || i_m_axis_tready);

    assign w_hit[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int NB = (g == DEPTH-1) ? g : g + 1;
        ceq_cell #(
            .TOPIC_BITS (TOPIC_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_load       (w_load),
            .i_valid      (CW'(g) < r_count),
            .i_cmp_topic  (i_s_axis_tdata[TOPIC_BITS-1:0]),
            .i_ctl        (w_ctl),
            .i_app_sel    (w_app_sel[g]),
            .i_hit_before (w_hit[g]),
            .o_hit_before (w_hit[g+1]),
            .i_new_topic  (r_topic),
            .i_new_value  (r_value),
            .i_new_time   (r_now),
            .i_nbr_topic  (w_topic[NB]),
            .i_nbr_value  (w_value[NB]),
            .i_nbr_time   (w_time[NB]),
            .o_topic      (w_topic[g]),
            .o_value      (w_value[g]),
            .o_time       (w_time[g])
        );
        assign w_app_sel[g] = w_go && n_append && (n_app_idx == IW'(g));
    end

    always_comb begin
        n_limit_eff = CMPW'(r_limit);
        if (n_limit_eff > DEPTH_C) begin
            n_limit_eff = DEPTH_C;
        end
        n_count_ext = CMPW'(r_count);
        n_hit    = w_hit[DEPTH];
        n_since  = r_now - r_last_send;
        n_drop   = 1'b0;
        n_append = 1'b0;
        n_app_idx = IW'(r_count);
        n_send_ok = 1'b0;
        n_count  = r_count;
        w_ctl    = '0;
        n_out_data = '0;
        if (r_cmd == CMD_POST) begin
            if (n_hit) begin
                w_ctl.coalesce = w_go;
            end else begin
                n_drop = (n_count_ext >= n_limit_eff) && (r_count != '0);
                n_append = n_drop || (r_count != DEPTH_N);
                if (n_drop) begin
                    n_app_idx = IW'(r_count - CW'(1));
                end else if (n_append) begin
                    n_count = r_count + CW'(1);
                end
                w_ctl.shift = w_go && n_drop;
            end
            n_out_data[OUT_RAW-CW-2] = n_hit;
            n_out_data[OUT_RAW-CW-1] = n_drop;
        end else begin
            n_send_ok = r_link && (r_count != '0) &&
                        (n_since >= TIME_BITS'(r_gap));
            if (n_send_ok) begin
                n_count = r_count - CW'(1);
                n_out_data[0] = 1'b1;
                n_out_data[TOPIC_BITS:1] = w_topic[0];
                n_out_data[TOPIC_BITS+VALUE_BITS:TOPIC_BITS+1] = w_value[0];
                n_out_data[OUT_RAW-CW-3:TOPIC_BITS+VALUE_BITS+1] = r_now - w_time[0];
            end
            w_ctl.shift = w_go && n_send_ok;
        end
        n_out_data[OUT_RAW-1:OUT_RAW-CW] = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_last_send <= '0;
            r_gap       <= RATE_GAP_RESET;
            r_limit     <= QUEUE_LIMIT_RESET;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_go) begin
                r_busy <= 1'b0;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                if (n_send_ok) begin
                    r_last_send <= r_now;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_RATE_GAP:    r_gap   <= i_cfg_data[GAP_BITS-1:0];
                    CFG_QUEUE_LIMIT: r_limit <= i_cfg_data[LIMIT_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd   <= i_s_axis_tuser;
            r_topic <= i_s_axis_tdata[TOPIC_BITS-1:0];
            r_value <= i_s_axis_tdata[IN_NOW-1:IN_VAL];
            r_now   <= i_s_axis_tdata[IN_LNK-1:IN_NOW];
            r_link  <= i_s_axis_tdata[IN_LNK];
        end
        if (w_go) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: hdl/ceq_checker.sv
// Port-level checks for coalescing_event_queue, attached by bind.
// Depends on ceq_pkg; sees only the top-level ports.
module ceq_checker #(
    parameter int DEPTH      = 32,
    parameter int TOPIC_BITS = 8,
    parameter int VALUE_BITS = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic [((TOPIC_BITS+VALUE_BITS+ceq_pkg::TIME_BITS+1+7)/8)*8-1:0] i_s_axis_tdata,
    input logic i_s_axis_tuser,
    input logic i_s_axis_tvalid,
    input logic o_s_axis_tready,
    input logic [((TOPIC_BITS+VALUE_BITS+ceq_pkg::TIME_BITS+3+$clog2(DEPTH+1)+7)/8)*8-1:0]
                o_m_axis_tdata,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [ceq_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input logic [ceq_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import ceq_pkg::*;

    localparam int CW      = $clog2(DEPTH+1);
    localparam int OUT_RAW = TOPIC_BITS+VALUE_BITS+TIME_BITS+3+CW;
    localparam int SENT_HI = OUT_RAW-CW-3;

    logic          w_sent;
    logic          w_coal;
    logic          w_drop;
    logic [CW-1:0] w_occ;

    assign w_sent = o_m_axis_tdata[0];
    assign w_coal = o_m_axis_tdata[OUT_RAW-CW-2];
    assign w_drop = o_m_axis_tdata[OUT_RAW-CW-1];
    assign w_occ  = o_m_axis_tdata[OUT_RAW-1:OUT_RAW-CW];

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_occ <= CW'(DEPTH)))
        else $error("occupancy above depth");

    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(w_sent && (w_coal || w_drop)) && !(w_coal && w_drop))
        else $error("result flags not exclusive");

    a_unsent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !w_sent) |-> (o_m_axis_tdata[SENT_HI:1] == '0))
        else $error("unsent result carries data");

    a_coal_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && w_coal) ##1
        (o_m_axis_tvalid && i_m_axis_tready && w_sent) |->
        ($past(w_occ) == w_occ + CW'(1)))
        else $error("send after coalesce did not reduce occupancy by one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind coalescing_event_queue ceq_checker #(
    .DEPTH      (DEPTH),
    .TOPIC_BITS (TOPIC_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_ceq_checker (.*);

// File: dv/ceq_checker.sv
// Scoreboard for the coalescing event queue: tracks the pending entries, send time and
// registers from the observed transfers, and compares each result field by field.
// Depends on ceq_pkg.
module ceq_scoreboard #(
    parameter int DEPTH      = 32,
    parameter int TOPIC_BITS = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [((TOPIC_BITS+VALUE_BITS+ceq_pkg::TIME_BITS+1+7)/8)*8-1:0] i_s_tdata,
    input  logic                     i_s_tuser,
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tready,
    input  logic [((TOPIC_BITS+VALUE_BITS+ceq_pkg::TIME_BITS+3+$clog2(DEPTH+1)+7)/8)*8-1:0]
                                     i_m_tdata,
    input  logic                     i_m_tvalid,
    input  logic                     i_m_tready,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [ceq_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [ceq_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_mismatches,
    output int                       o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import ceq_pkg::*;

    localparam int OCC_BITS = $clog2(DEPTH+1);
    localparam int OUT_W    = ((TOPIC_BITS+VALUE_BITS+TIME_BITS+3+OCC_BITS+7)/8)*8;
    // result field offsets, lowest bit first
    localparam int AT_TOPIC = 1;
    localparam int AT_VALUE = AT_TOPIC + TOPIC_BITS;
    localparam int AT_AGE   = AT_VALUE + VALUE_BITS;
    localparam int AT_COAL  = AT_AGE + TIME_BITS;
    localparam int AT_DROP  = AT_COAL + 1;
    localparam int AT_OCC   = AT_DROP + 1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                  sent;
        logic [TOPIC_BITS-1:0] topic;
        logic [VALUE_BITS-1:0] value;
        logic [TIME_BITS-1:0]  age;
        logic                  coalesced;
        logic                  dropped;
        logic [OCC_BITS-1:0]   occupancy;
    } t_report;

    logic [TOPIC_BITS-1:0] pend_topic [DEPTH];
    logic [VALUE_BITS-1:0] pend_value [DEPTH];
    logic [TIME_BITS-1:0]  pend_time  [DEPTH];
    int unsigned           pend_count;
    logic [TIME_BITS-1:0]  last_sent_ms;
    logic [GAP_BITS-1:0]   rate_gap;
    logic [LIMIT_BITS-1:0] queue_limit;
    t_report               expected_reports [$];

    task automatic pop_oldest();
        int i;
        if (pend_count == 0)
            return;
        for (i = 1; i < pend_count; i++) begin
            pend_topic[i-1] = pend_topic[i];
            pend_value[i-1] = pend_value[i];
            pend_time[i-1]  = pend_time[i];
        end
        pend_count--;
    endtask

    // Updates the pending entries for one item and forms the result it yields.
    task automatic apply_event(input logic cmd, input logic [TOPIC_BITS-1:0] topic,
                               input logic [VALUE_BITS-1:0] value,
                               input logic [TIME_BITS-1:0] now, input logic link_up,
                               output t_report rep);
        int unsigned          cap;
        int                   hit;
        int                   i;
        logic [TIME_BITS-1:0] since;
        rep = '0;
        if (cmd == CMD_POST) begin
            cap = (queue_limit > DEPTH) ? DEPTH : queue_limit;
            hit = -1;
            for (i = 0; i < pend_count; i++)
                if (hit < 0 && pend_topic[i] == topic)
                    hit = i;
            if (hit >= 0) begin
                pend_value[hit] = value;
                pend_time[hit]  = now;
                rep.coalesced   = 1'b1;
            end else begin
                if (pend_count >= cap && pend_count > 0) begin
                    pop_oldest();
                    rep.dropped = 1'b1;
                end
                if (pend_count < DEPTH) begin
                    pend_topic[pend_count] = topic;
                    pend_value[pend_count] = value;
                    pend_time[pend_count]  = now;
                    pend_count++;
                end
            end
        end else begin
            since = now - last_sent_ms;
            if (link_up && pend_count > 0 && since >= rate_gap) begin
                rep.sent  = 1'b1;
                rep.topic = pend_topic[0];
                rep.value = pend_value[0];
                rep.age   = now - pend_time[0];
                pop_oldest();
                last_sent_ms = now;
            end
        end
        rep.occupancy = OCC_BITS'(pend_count);
    endtask

    function automatic t_report unpack_report(input logic [OUT_W-1:0] word);
        t_report r;
        r.sent      = word[0];
        r.topic     = word[AT_TOPIC +: TOPIC_BITS];
        r.value     = word[AT_VALUE +: VALUE_BITS];
        r.age       = word[AT_AGE +: TIME_BITS];
        r.coalesced = word[AT_COAL];
        r.dropped   = word[AT_DROP];
        r.occupancy = word[AT_OCC +: OCC_BITS];
        return r;
    endfunction

    function automatic string describe(input t_report r);
        return $sformatf("sent=%0d topic=%h value=%h age=%h coalesced=%0d dropped=%0d occ=%0d",
                         r.sent, r.topic, r.value, r.age, r.coalesced, r.dropped,
                         r.occupancy);
    endfunction

    always @(posedge i_clk) begin
        t_report seen;
        t_report want;
        t_report fresh;
        logic    bad;
        if (!i_rst_n) begin
            pend_count   = 0;
            last_sent_ms = '0;
            rate_gap     = RATE_GAP_RESET;
            queue_limit  = QUEUE_LIMIT_RESET;
            expected_reports.delete();
        end else begin
            // results first: one accepted at this edge can't belong to an item taken now
            if (i_m_tvalid && i_m_tready) begin
                seen = unpack_report(i_m_tdata);
                if (expected_reports.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT)
                        $display("%t: result with nothing expected: %s", $realtime,
                                 describe(seen));
                end else begin
                    want = expected_reports[0];
                    expected_reports.delete(0);
                    bad = (seen.sent !== want.sent) || (seen.topic !== want.topic) ||
                          (seen.value !== want.value) || (seen.age !== want.age) ||
                          (seen.coalesced !== want.coalesced) ||
                          (seen.dropped !== want.dropped) ||
                          (seen.occupancy !== want.occupancy);
                    if (bad) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_LIMIT) begin
                            $display("%t: result mismatch", $realtime);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(seen));
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RATE_GAP:    rate_gap    = i_cfg_data[GAP_BITS-1:0];
                    CFG_QUEUE_LIMIT: queue_limit = i_cfg_data[LIMIT_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_event(i_s_tuser, i_s_tdata[TOPIC_BITS-1:0],
                            i_s_tdata[TOPIC_BITS +: VALUE_BITS],
                            i_s_tdata[TOPIC_BITS+VALUE_BITS +: TIME_BITS],
                            i_s_tdata[TOPIC_BITS+VALUE_BITS+TIME_BITS], fresh);
                expected_reports = {expected_reports, fresh};
            end
        end
        o_outstanding = expected_reports.size();
    end

endmodule

// File: dv/coalescing_event_queue_test.sv
// Testbench top for coalescing_event_queue: clock, reset, register writes, event and
// send-attempt stimulus with bursty input and a stalling output side; ceq_scoreboard judges.
// Depends on ceq_pkg, ceq_scoreboard and the block itself.
module coalescing_event_queue_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ceq_pkg::*;

    localparam int DEPTH      = 32;
    localparam int TOPIC_BITS = 8;
    localparam int VALUE_BITS = 32;
    localparam int IN_W  = ((TOPIC_BITS+VALUE_BITS+TIME_BITS+1+7)/8)*8;
    localparam int OUT_W = ((TOPIC_BITS+VALUE_BITS+TIME_BITS+3+$clog2(DEPTH+1)+7)/8)*8;
    localparam int PHASE_ITEMS   = 250;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 4;
    localparam int POOL_MAX      = 48;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = CFG_IDX_BITS'(8'hFF);

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic [IN_W-1:0]          s_tdata = '0;
    logic                     s_tuser = CMD_POST;
    logic                     s_tvalid = 1'b0;
    wire                      s_tready;
    wire [OUT_W-1:0]          m_tdata;
    wire                      m_tvalid;
    logic                     m_tready = 1'b0;
    logic                     cfg_valid = 1'b0;
    wire                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    int                       mismatches;
    int                       outstanding;

    // stimulus state
    logic [TIME_BITS-1:0]  clock_ms = '0;
    logic [TOPIC_BITS-1:0] topic_pool [POOL_MAX];
    int                    pool_size = 8;
    int                    post_pct = 55;
    int unsigned           step_max = 100;
    int                    burst_left = 0;
    int                    hold_requests = 0;
    // receiver state
    int                    hold_seen = 0;
    int                    hold_left = 0;
    int                    rx_mode = 0;
    int                    mode_left = 0;
    int                    stalled_cycles = 0;

    coalescing_event_queue #(
        .DEPTH(DEPTH), .TOPIC_BITS(TOPIC_BITS), .VALUE_BITS(VALUE_BITS)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_s_axis_tdata(s_tdata),
        .i_s_axis_tuser(s_tuser),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .o_m_axis_tdata(m_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    ceq_scoreboard #(
        .DEPTH(DEPTH), .TOPIC_BITS(TOPIC_BITS), .VALUE_BITS(VALUE_BITS)
    ) checker_inst (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser),
        .i_s_tvalid(s_tvalid),
        .i_s_tready(s_tready),
        .i_m_tdata(m_tdata),
        .i_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .o_mismatches(mismatches),
        .o_outstanding(outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Output side: random stall pattern, plus a long hold-off on request.
    always @(posedge clk) begin
        if (hold_seen != hold_requests) begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_requests;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles == STALL_LIMIT) begin
            $display("coalescing_event_queue_test NOT OK");
            $finish;
        end
    end

    // One input transfer; the sender runs in bursts separated by random gaps.
    task automatic offer(input logic cmd, input logic [TOPIC_BITS-1:0] topic,
                         input logic [VALUE_BITS-1:0] value,
                         input logic [TIME_BITS-1:0] now, input logic link_up);
        logic [IN_W-1:0] word;
        int unsigned     gap;
        word = '0;
        word[TOPIC_BITS-1:0]                      = topic;
        word[TOPIC_BITS +: VALUE_BITS]            = value;
        word[TOPIC_BITS+VALUE_BITS +: TIME_BITS]  = now;
        word[TOPIC_BITS+VALUE_BITS+TIME_BITS]     = link_up;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic post_event(input logic [TOPIC_BITS-1:0] topic,
                              input logic [VALUE_BITS-1:0] value,
                              input logic [TIME_BITS-1:0] now);
        offer(CMD_POST, topic, value, now, 1'($urandom_range(0, 1)));
    endtask

    task automatic try_send(input logic [TIME_BITS-1:0] now, input logic link_up);
        offer(CMD_SEND, TOPIC_BITS'($urandom), VALUE_BITS'($urandom), now, link_up);
    endtask

    // Stop offering and wait until every result is back and the block is quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [TOPIC_BITS-1:0] pick_topic();
        if ($urandom_range(0, 99) < 85)
            return topic_pool[$urandom_range(0, pool_size - 1)];
        return TOPIC_BITS'($urandom);
    endfunction

    task automatic random_event();
        if ($urandom_range(0, 99) < 2)
            clock_ms = $urandom;  // time jump, may go backwards
        else
            clock_ms = clock_ms + $urandom_range(0, step_max);
        if ($urandom_range(0, 99) < post_pct)
            post_event(pick_topic(), VALUE_BITS'($urandom), clock_ms);
        else
            try_send(clock_ms, $urandom_range(0, 99) < 85);
    endtask

    // Pool of distinct topics: an odd stride from a random base never repeats.
    task automatic shape_traffic(input int pool, input int pct, input int unsigned step);
        logic [TOPIC_BITS-1:0] base;
        logic [TOPIC_BITS-1:0] stride;
        int                    i;
        base   = TOPIC_BITS'($urandom);
        stride = TOPIC_BITS'($urandom) | TOPIC_BITS'(1);
        for (i = 0; i < POOL_MAX; i++)
            topic_pool[i] = base + TOPIC_BITS'(i) * stride;
        pool_size = pool;
        post_pct  = pct;
        step_max  = step;
    endtask

    task automatic configure(input logic [CFG_DATA_BITS-1:0] gap,
                             input logic [CFG_DATA_BITS-1:0] limit);
        settle();
        write_reg(CFG_RATE_GAP, gap);
        write_reg(CFG_QUEUE_LIMIT, limit);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: gap 150, limit 30
        try_send(32'd500, 1'b1);                       // empty queue
        post_event(8'h00, 32'h0000_0000, 32'd0);
        post_event(8'hFF, 32'hFFFF_FFFF, 32'd10);
        post_event(8'h00, 32'h1234_5678, 32'd20);       // coalesces in place
        try_send(32'd1000, 1'b0);                       // link down
        try_send(32'd100, 1'b1);                        // too soon after time zero
        try_send(32'd150, 1'b1);                        // exactly the gap
        try_send(32'd299, 1'b1);                        // one short of the gap
        post_event(8'h80, 32'h8000_0000, 32'hFFFF_FFF0);
        try_send(32'd300, 1'b1);
        post_event(8'h7F, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        try_send(32'hFFFF_FF00, 1'b1);                  // age wraps
        try_send(32'h0000_0050, 1'b1);                  // gap measured across the wrap
        try_send(32'h0000_1000, 1'b1);                  // empty again
        clock_ms = 32'h0000_2000;
        shape_traffic(16, 55, 100);
        repeat (PHASE_ITEMS) random_event();

        configure(16'd0, 16'd32);
        shape_traffic(40, 70, 5);
        hold_requests++;
        repeat (PHASE_ITEMS) random_event();

        configure(16'hFFFF, 16'd1);
        shape_traffic(6, 50, 20000);
        repeat (PHASE_ITEMS) random_event();

        // limit zero: start from an empty queue
        configure(16'd100, 16'd0);
        repeat (DEPTH + 1) begin
            clock_ms = clock_ms + 70000;
            try_send(clock_ms, 1'b1);
        end
        post_event(8'h11, VALUE_BITS'($urandom), clock_ms);  // nothing to evict
        post_event(8'h22, VALUE_BITS'($urandom), clock_ms);
        post_event(8'h22, VALUE_BITS'($urandom), clock_ms);
        post_event(8'h33, VALUE_BITS'($urandom), clock_ms);
        shape_traffic(6, 55, 60);
        repeat (PHASE_ITEMS) random_event();

        // limit field at its top saturates to the depth; the unmapped write must not land
        configure(16'd300, 16'hFFFF);
        write_reg(CFG_UNMAPPED, 16'h0001);
        shape_traffic(40, 80, 50);
        hold_requests++;
        repeat (PHASE_ITEMS / 2) random_event();
        hold_requests++;
        repeat (PHASE_ITEMS / 2) random_event();

        configure(16'd5, 16'd4);
        shape_traffic(8, 55, 4);
        repeat (PHASE_ITEMS) random_event();

        configure(16'd150, 16'd30);
        shape_traffic(40, 60, 100);
        repeat (PHASE_ITEMS) random_event();

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("coalescing_event_queue_test OK");
        else
            $display("coalescing_event_queue_test NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
hdl/ceq_pkg.sv
hdl/ceq_cell.sv
hdl/coalescing_event_queue.sv
hdl/ceq_checker.sv
dv/ceq_checker.sv
dv/coalescing_event_queue_test.sv
